/* rtl/vna_pkg.sv */
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_COUNT = 32768;
    localparam int IDX_WIDTH    = $clog2(VERTEX_COUNT);
    localparam int COORD_WIDTH  = 16;
    localparam int COUNT_WIDTH  = 8;
    localparam int SUM_WIDTH    = 43;
    localparam int NORMAL_WIDTH = 36;
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
    localparam int DIV_STEPS    = SUM_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FACE = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                           op;
        logic [IDX_WIDTH-1:0]          idx_a;
        logic [IDX_WIDTH-1:0]          idx_b;
        logic [IDX_WIDTH-1:0]          idx_c;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } t_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_DIFF,
        ST_MUL,
        ST_SUB,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_SUM,
        ST_SIGN,
        ST_DIV,
        ST_FIX,
        ST_EMIT,
        ST_CLEAR
    } t_state;

endpackage

/* rtl/vna_front.sv */
// ----------------------------------------------------------------------------
// vna_front
// Request intake: drops unused ops and pushes into a queue.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  t_req                    i_req,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_valid,
    output t_req                    o_req
);

    t_req r_q [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QUEUE_DEPTH):0]   r_cnt, n_cnt;
    logic                           w_wr;

    // unused op makes no entry
    assign w_wr    = i_push && !o_full && (i_req.op != OP_NONE);
    assign o_full  = (r_cnt == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !(i_pop && o_valid)) n_cnt = r_cnt + 1'b1;
        else if (!w_wr && i_pop && o_valid) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (i_pop && o_valid) r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= i_req;
    end

endmodule

/* rtl/vna_back.sv */
// ----------------------------------------------------------------------------
// vna_back
// Execution engine: vertex and sum memories, cross product, bit-serial divide.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  t_req                           i_req,
    output logic                           o_pop,
    output logic                           o_strobe,
    output logic [1:0]                     o_kind,
    output logic signed [NORMAL_WIDTH-1:0] o_normal_x,
    output logic signed [NORMAL_WIDTH-1:0] o_normal_y,
    output logic signed [NORMAL_WIDTH-1:0] o_normal_z,
    output logic [COUNT_WIDTH-1:0]         o_face_count,
    output logic                           o_empty_flag
);

    localparam int VW = 3 * COORD_WIDTH;
    localparam int SW = 3 * SUM_WIDTH + COUNT_WIDTH;

    t_state r_st, n_st;
    t_req   r_req;

    logic [VW-1:0] r_vmem [VERTEX_COUNT];
    logic [SW-1:0] r_smem [VERTEX_COUNT];
    logic [VW-1:0] r_vrd;
    logic [SW-1:0] r_srd;

    logic [IDX_WIDTH-1:0] r_clr;
    logic [1:0]           r_corner;

    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [DIFF_WIDTH-1:0]  r_ux, r_uy, r_uz, r_wx, r_wy, r_wz;
    logic signed [PROD_WIDTH-1:0]  r_p [6];
    logic signed [PROD_WIDTH:0]    r_nx, r_ny, r_nz;

    // divide state: three lanes share one step counter
    logic [SUM_WIDTH-1:0]   r_mag [3];
    logic [SUM_WIDTH-1:0]   r_quo [3];
    logic [COUNT_WIDTH:0]   r_rem [3];
    logic [2:0]             r_neg;
    logic [COUNT_WIDTH-1:0] r_den;
    logic [$clog2(DIV_STEPS)-1:0] r_step;

    logic                           r_stb;
    logic [1:0]                     r_kind;
    logic signed [NORMAL_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic [COUNT_WIDTH-1:0]         r_ofc;
    logic                           r_oempty;

    logic [IDX_WIDTH-1:0] w_vaddr, w_corner_idx;
    logic [SUM_WIDTH-1:0] w_sx, w_sy, w_sz;
    logic [COUNT_WIDTH-1:0] w_cnt;

    assign w_sx  = r_srd[SW-1 -: SUM_WIDTH];
    assign w_sy  = r_srd[SW-1-SUM_WIDTH -: SUM_WIDTH];
    assign w_sz  = r_srd[SW-1-2*SUM_WIDTH -: SUM_WIDTH];
    assign w_cnt = r_srd[COUNT_WIDTH-1:0];

    always_comb begin
        case (r_corner)
            2'd0:    w_corner_idx = r_req.idx_a;
            2'd1:    w_corner_idx = r_req.idx_b;
            default: w_corner_idx = r_req.idx_c;
        endcase
    end

    always_comb begin
        case (r_st)
            ST_RD_A: w_vaddr = r_req.idx_a;
            ST_RD_B: w_vaddr = r_req.idx_b;
            default: w_vaddr = r_req.idx_c;
        endcase
    end

    assign o_pop  = (r_st == ST_IDLE) && i_valid;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR:  if (r_clr == '1) n_st = ST_IDLE;
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_req.op)
                        OP_LOAD: n_st = ST_EMIT;
                        OP_FACE: n_st = ST_RD_A;
                        default: n_st = ST_RD_SUM;
                    endcase
                end
            end
            ST_RD_A:   n_st = ST_RD_B;
            ST_RD_B:   n_st = ST_RD_C;
            ST_RD_C:   n_st = ST_DIFF;
            ST_DIFF:   n_st = ST_MUL;
            ST_MUL:    n_st = ST_SUB;
            ST_SUB:    n_st = ST_ACC_RD;
            ST_ACC_RD: n_st = ST_ACC_WR;
            ST_ACC_WR: n_st = (r_corner == 2'd2) ? ST_EMIT : ST_ACC_RD;
            ST_RD_SUM: n_st = ST_SIGN;
            ST_SIGN:   n_st = (w_cnt == '0) ? ST_EMIT : ST_DIV;
            ST_DIV:    if (r_step == '0) n_st = ST_FIX;
            ST_FIX:    n_st = ST_EMIT;
            ST_EMIT:   n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_CLEAR;
            r_clr    <= '0;
            r_stb    <= 1'b0;
            r_corner <= '0;
        end else begin
            r_st  <= n_st;
            r_stb <= (r_st == ST_EMIT);
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_st == ST_SUB) r_corner <= '0;
            else if (r_st == ST_ACC_WR) r_corner <= r_corner + 1'b1;
        end
    end

    // memories: one write and one read per cycle each
    always_ff @(posedge i_clk) begin
        if (o_pop && i_req.op == OP_LOAD)
            r_vmem[i_req.idx_a] <= {i_req.cx, i_req.cy, i_req.cz};
        r_vrd <= r_vmem[w_vaddr];
    end

    logic [SW-1:0] w_swr;
    logic          w_swe;
    logic [IDX_WIDTH-1:0] w_swa, w_sra;

    always_comb begin
        w_swe = 1'b0;
        w_swa = w_corner_idx;
        w_swr = r_srd;
        w_sra = (r_st == ST_ACC_RD) ? w_corner_idx : r_req.idx_a;
        if (r_st == ST_CLEAR) begin
            w_swe = 1'b1;
            w_swa = r_clr;
            w_swr = '0;
        end else if (r_st == ST_ACC_WR && w_cnt != COUNT_MAX) begin
            w_swe = 1'b1;
            w_swr = {w_sx + SUM_WIDTH'(r_nx), w_sy + SUM_WIDTH'(r_ny),
                     w_sz + SUM_WIDTH'(r_nz), w_cnt + 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) r_smem[w_swa] <= w_swr;
        r_srd <= r_smem[w_sra];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_req <= i_req;
        case (r_st)
            ST_RD_B: {r_ax, r_ay, r_az} <= r_vrd;
            ST_RD_C: {r_bx, r_by, r_bz} <= r_vrd;
            ST_DIFF: begin
                r_ux <= DIFF_WIDTH'(r_bx) - DIFF_WIDTH'(r_ax);
                r_uy <= DIFF_WIDTH'(r_by) - DIFF_WIDTH'(r_ay);
                r_uz <= DIFF_WIDTH'(r_bz) - DIFF_WIDTH'(r_az);
                r_wx <= DIFF_WIDTH'($signed(r_vrd[VW-1 -: COORD_WIDTH])) - DIFF_WIDTH'(r_ax);
                r_wy <= DIFF_WIDTH'($signed(r_vrd[VW-1-COORD_WIDTH -: COORD_WIDTH]))
                        - DIFF_WIDTH'(r_ay);
                r_wz <= DIFF_WIDTH'($signed(r_vrd[COORD_WIDTH-1:0])) - DIFF_WIDTH'(r_az);
            end
            ST_MUL: begin
                r_p[0] <= r_uy * r_wz;
                r_p[1] <= r_uz * r_wy;
                r_p[2] <= r_uz * r_wx;
                r_p[3] <= r_ux * r_wz;
                r_p[4] <= r_ux * r_wy;
                r_p[5] <= r_uy * r_wx;
            end
            ST_SUB: begin
                r_nx <= (PROD_WIDTH+1)'(r_p[0]) - (PROD_WIDTH+1)'(r_p[1]);
                r_ny <= (PROD_WIDTH+1)'(r_p[2]) - (PROD_WIDTH+1)'(r_p[3]);
                r_nz <= (PROD_WIDTH+1)'(r_p[4]) - (PROD_WIDTH+1)'(r_p[5]);
            end
            ST_SIGN: begin
                r_neg  <= {w_sx[SUM_WIDTH-1], w_sy[SUM_WIDTH-1], w_sz[SUM_WIDTH-1]};
                r_mag[0] <= w_sx[SUM_WIDTH-1] ? -w_sx : w_sx;
                r_mag[1] <= w_sy[SUM_WIDTH-1] ? -w_sy : w_sy;
                r_mag[2] <= w_sz[SUM_WIDTH-1] ? -w_sz : w_sz;
                for (int i = 0; i < 3; i++) r_rem[i] <= '0;
                r_den  <= w_cnt;
                r_step <= ($clog2(DIV_STEPS))'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per lane per cycle
                for (int i = 0; i < 3; i++) begin
                    logic [COUNT_WIDTH+1:0] t;
                    t = {r_rem[i], r_mag[i][SUM_WIDTH-1]} - {2'b0, r_den};
                    if (!t[COUNT_WIDTH+1]) r_rem[i] <= t[COUNT_WIDTH:0];
                    else r_rem[i] <= {r_rem[i][COUNT_WIDTH-1:0], r_mag[i][SUM_WIDTH-1]};
                    r_mag[i] <= {r_mag[i][SUM_WIDTH-2:0], 1'b0};
                    r_quo[i] <= {r_quo[i][SUM_WIDTH-2:0], !t[COUNT_WIDTH+1]};
                end
                r_step <= r_step - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_EMIT) begin
            r_kind   <= r_req.op;
            r_ox     <= '0;
            r_oy     <= '0;
            r_oz     <= '0;
            r_ofc    <= '0;
            r_oempty <= 1'b0;
            if (r_req.op == OP_FACE) begin
                r_ox <= NORMAL_WIDTH'(r_nx);
                r_oy <= NORMAL_WIDTH'(r_ny);
                r_oz <= NORMAL_WIDTH'(r_nz);
            end else if (r_req.op == OP_READ) begin
                if (r_den == '0 || w_cnt == '0) begin
                    r_oempty <= 1'b1;
                end else begin
                    r_ox  <= r_neg[2] ? -NORMAL_WIDTH'(r_quo[0]) : NORMAL_WIDTH'(r_quo[0]);
                    r_oy  <= r_neg[1] ? -NORMAL_WIDTH'(r_quo[1]) : NORMAL_WIDTH'(r_quo[1]);
                    r_oz  <= r_neg[0] ? -NORMAL_WIDTH'(r_quo[2]) : NORMAL_WIDTH'(r_quo[2]);
                    r_ofc <= r_den;
                end
            end
        end
    end

    assign o_strobe     = r_stb;
    assign o_kind       = r_kind;
    assign o_normal_x   = r_ox;
    assign o_normal_y   = r_oy;
    assign o_normal_z   = r_oz;
    assign o_face_count = r_ofc;
    assign o_empty_flag = r_oempty;

endmodule

/* rtl/vertex_normal_accumulator.sv */
// The back end takes one request at a time and a two-entry queue takes start meanwhile.
// Face time is set by three read-modify-write passes, read time by a 43-step divide.
// Reset: clears the sum memory; up to two requests queue meanwhile.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Top level: request queue in front of the normal engine.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator import vna_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_op,
    input  logic [14:0]                    i_vertex_index,
    input  logic signed [15:0]             i_coord_x,
    input  logic signed [15:0]             i_coord_y,
    input  logic signed [15:0]             i_coord_z,
    input  logic [14:0]                    i_corner_a,
    input  logic [14:0]                    i_corner_b,
    input  logic [14:0]                    i_corner_c,
    output logic                           o_strobe,
    output logic [1:0]                     o_kind,
    output logic signed [35:0]             o_normal_x,
    output logic signed [35:0]             o_normal_y,
    output logic signed [35:0]             o_normal_z,
    output logic [7:0]                     o_face_count,
    output logic                           o_empty_flag
);

    t_req w_req, w_qreq;
    logic w_full, w_qv, w_pop;

    always_comb begin
        w_req.op    = t_op'(i_op);
        w_req.idx_a = (i_op == OP_FACE) ? i_corner_a[IDX_WIDTH-1:0]
                                        : i_vertex_index[IDX_WIDTH-1:0];
        w_req.idx_b = i_corner_b[IDX_WIDTH-1:0];
        w_req.idx_c = i_corner_c[IDX_WIDTH-1:0];
        w_req.cx    = i_coord_x[COORD_WIDTH-1:0];
        w_req.cy    = i_coord_y[COORD_WIDTH-1:0];
        w_req.cz    = i_coord_z[COORD_WIDTH-1:0];
    end

    assign busy = w_full;

    vna_front u_front (
        .i_clk, .i_rst_n,
        .i_push (start),
        .i_req  (w_req),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_valid(w_qv),
        .o_req  (w_qreq)
    );

    vna_back u_back (
        .i_clk, .i_rst_n,
        .i_valid     (w_qv),
        .i_req       (w_qreq),
        .o_pop       (w_pop),
        .o_strobe, .o_kind, .o_normal_x, .o_normal_y, .o_normal_z,
        .o_face_count, .o_empty_flag
    );

endmodule
